### rtl/grh_pkg.sv
package grh_pkg;

  // Fixed point formats
  localparam int FRAC_BITS = 8;
  localparam int COT_FRAC  = 16;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field widths
  localparam int POS_W   = 24;
  localparam int COT_W   = 24;
  localparam int SHIFT_W = 4;
  localparam int MAPN_W  = 7;
  localparam int CELL_W  = 6;

  // Internal arithmetic widths
  localparam int HS_W     = 5;               // tile shift plus fraction bits, up to 23
  localparam int XW       = 36;              // walk x, signed
  localparam int YW       = 27;              // walk y, signed
  localparam int DIFF_W   = 25;              // first line minus player y
  localparam int PROD_W   = DIFF_W + COT_W;
  localparam int XS_TMP_W = 48;              // cotangent scaled by tile height

  // Stream layout
  localparam int S_TDATA_W  = 96;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 48;
  localparam int M_TUSER_W  = 1;

  localparam int S_ROW_LSB   = 0;
  localparam int S_COL_LSB   = 6;
  localparam int S_WALL_BIT  = 12;
  localparam int S_PX_LSB    = 13;
  localparam int S_PY_LSB    = 37;
  localparam int S_COT_LSB   = 61;
  localparam int S_UP_BIT    = 85;
  localparam int S_DOWN_BIT  = 86;
  localparam int S_LEFT_BIT  = 87;
  localparam int S_RIGHT_BIT = 88;

  localparam int M_HX_LSB = 0;
  localparam int M_HY_LSB = 24;

  // Opcodes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SHIFT_W = 3'd0,
    REG_TILE_SHIFT_H = 3'd1,
    REG_MAP_COLS     = 3'd2,
    REG_MAP_ROWS     = 3'd3,
    REG_VIEW_WIDTH   = 3'd4,
    REG_VIEW_HEIGHT  = 3'd5
  } reg_idx_e;

  localparam logic [SHIFT_W-1:0] TILE_SHIFT_RST  = 4'd6;
  localparam logic [MAPN_W-1:0]  MAP_N_RST       = 7'd64;
  localparam logic [POS_W-1:0]   VIEW_RST        = 24'd1048576;

  typedef struct packed {
    logic [SHIFT_W-1:0] tile_shift_w;
    logic [SHIFT_W-1:0] tile_shift_h;
    logic [MAPN_W-1:0]  map_cols;
    logic [MAPN_W-1:0]  map_rows;
    logic [POS_W-1:0]   view_width;
    logic [POS_W-1:0]   view_height;
  } cfg_t;

  typedef struct packed {
    logic cast_load;  // latch a cast item and set up the first line
    logic mul;        // form the offset product and the x step
    logic init;       // load the walk point
    logic issue;      // probe the current point and advance
    logic load_res;   // move the last probe into the output register
    logic map_write;  // store a cell
  } cmd_t;

  typedef struct packed {
    logic stop;       // last probe hit a wall or left the view
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

### rtl/grh_regs.sv
module grh_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [grh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [grh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output grh_pkg::cfg_t                      cfg_o
);

  grh_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (grh_pkg::reg_idx_e'(cfg_index_i))
        grh_pkg::REG_TILE_SHIFT_W: cfg_d.tile_shift_w = cfg_data_i[grh_pkg::SHIFT_W-1:0];
        grh_pkg::REG_TILE_SHIFT_H: cfg_d.tile_shift_h = cfg_data_i[grh_pkg::SHIFT_W-1:0];
        grh_pkg::REG_MAP_COLS:     cfg_d.map_cols     = cfg_data_i[grh_pkg::MAPN_W-1:0];
        grh_pkg::REG_MAP_ROWS:     cfg_d.map_rows     = cfg_data_i[grh_pkg::MAPN_W-1:0];
        grh_pkg::REG_VIEW_WIDTH:   cfg_d.view_width   = cfg_data_i[grh_pkg::POS_W-1:0];
        grh_pkg::REG_VIEW_HEIGHT:  cfg_d.view_height  = cfg_data_i[grh_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_shift_w <= grh_pkg::TILE_SHIFT_RST;
      cfg_q.tile_shift_h <= grh_pkg::TILE_SHIFT_RST;
      cfg_q.map_cols     <= grh_pkg::MAP_N_RST;
      cfg_q.map_rows     <= grh_pkg::MAP_N_RST;
      cfg_q.view_width   <= grh_pkg::VIEW_RST;
      cfg_q.view_height  <= grh_pkg::VIEW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/grh_map.sv
module grh_map #(
  parameter int DEPTH = grh_pkg::MAX_ROWS_DEF * grh_pkg::MAX_COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/grh_dp.sv
module grh_dp #(
  parameter int MAX_ROWS = grh_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = grh_pkg::MAX_COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  grh_pkg::cfg_t                     cfg_i,
  input  grh_pkg::cmd_t                     cmd_i,
  output grh_pkg::sts_t                     sts_o,
  input  logic [grh_pkg::S_TDATA_W-1:0]     s_tdata_i,
  input  logic                              m_tready_i,
  output logic                              m_tvalid_o,
  output logic [grh_pkg::M_TDATA_W-1:0]     m_tdata_o,
  output logic [grh_pkg::M_TUSER_W-1:0]     m_tuser_o
);

  localparam int XW     = grh_pkg::XW;
  localparam int YW     = grh_pkg::YW;
  localparam int POS_W  = grh_pkg::POS_W;
  localparam int COT_W  = grh_pkg::COT_W;
  localparam int DIFF_W = grh_pkg::DIFF_W;
  localparam int PROD_W = grh_pkg::PROD_W;
  localparam int HS_W   = grh_pkg::HS_W;
  localparam int TW     = grh_pkg::XS_TMP_W;
  localparam int CELL_W = grh_pkg::CELL_W;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RIW    = $clog2(MAX_ROWS);
  localparam int CIW    = $clog2(MAX_COLS);
  localparam int OFS_W  = PROD_W - grh_pkg::COT_FRAC;
  localparam logic signed [YW-1:0] LIFT = YW'(1) << grh_pkg::FRAC_BITS;

  // Input fields
  logic [CELL_W-1:0]        w_row, w_col;
  logic                     w_wall;
  logic [POS_W-1:0]         s_px, s_py;
  logic [COT_W-1:0]         s_cot;

  assign w_row  = s_tdata_i[grh_pkg::S_ROW_LSB +: CELL_W];
  assign w_col  = s_tdata_i[grh_pkg::S_COL_LSB +: CELL_W];
  assign w_wall = s_tdata_i[grh_pkg::S_WALL_BIT];
  assign s_px   = s_tdata_i[grh_pkg::S_PX_LSB +: POS_W];
  assign s_py   = s_tdata_i[grh_pkg::S_PY_LSB +: POS_W];
  assign s_cot  = s_tdata_i[grh_pkg::S_COT_LSB +: COT_W];

  // Setup registers
  logic [POS_W-1:0]         px_q;
  logic signed [COT_W-1:0]  cot_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [YW-1:0]     y0_q, ys_q;
  logic                     up_q, left_q, right_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [XW-1:0]     xs_q;

  // Walk point and probe stage
  logic signed [XW-1:0]     x_q;
  logic signed [YW-1:0]     y_q;
  logic                     pr_valid_q, pr_view_q, pr_map_q;
  logic [POS_W-1:0]         pr_x_q, pr_y_q;
  logic                     rdata;

  // Output register
  logic                     out_valid_q;
  logic [POS_W-1:0]         out_x_q, out_y_q;
  logic                     out_f_q;

  logic [HS_W-1:0]          hs, ws;
  logic signed [YW-1:0]     pyw, th, yfl, y0, diff;
  logic signed [TW-1:0]     ct, ct_sh;
  logic signed [XW-1:0]     xs0, xs1, xs2, x0, vw;
  logic signed [YW-1:0]     vh, yp;
  logic [XW-1:0]            colw;
  logic [YW-1:0]            roww;
  logic                     in_view, col_ok, row_ok, in_map, found;
  logic                     w_ok;
  logic [AW-1:0]            waddr, raddr;

  assign hs = HS_W'(cfg_i.tile_shift_h) + HS_W'(grh_pkg::FRAC_BITS);
  assign ws = HS_W'(cfg_i.tile_shift_w) + HS_W'(grh_pkg::FRAC_BITS);

  // First horizontal line: the player's tile edge, or the next line below when facing down
  always_comb begin
    pyw  = $signed({{(YW-POS_W){1'b0}}, s_py});
    th   = $signed(YW'(1) << hs);
    yfl  = (pyw >>> hs) <<< hs;
    y0   = s_tdata_i[grh_pkg::S_DOWN_BIT] ? yfl + th : yfl;
    diff = y0 - pyw;
  end

  // X step: tile height times cotangent, floor, then facing fixups; also the start x
  always_comb begin
    ct    = $signed({{(TW-COT_W){cot_q[COT_W-1]}}, cot_q});
    ct_sh = (ct <<< hs) >>> grh_pkg::COT_FRAC;
    xs0   = $signed(ct_sh[XW-1:0]);
    xs1   = (left_q && !xs0[XW-1] && (xs0 != '0)) ? -xs0 : xs0;
    xs2   = (right_q && xs1[XW-1]) ? -xs1 : xs1;
    x0    = $signed({{(XW-POS_W){1'b0}}, px_q})
          + $signed({{(XW-OFS_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:grh_pkg::COT_FRAC]});
  end

  // Probe of the current point
  always_comb begin
    vw      = $signed({{(XW-POS_W){1'b0}}, cfg_i.view_width});
    vh      = $signed({{(YW-POS_W){1'b0}}, cfg_i.view_height});
    in_view = !x_q[XW-1] && (x_q != '0) && (x_q < vw)
           && !y_q[YW-1] && (y_q != '0) && (y_q < vh);
    yp      = up_q ? y_q - LIFT : y_q;
    colw    = x_q >> ws;
    roww    = yp >> hs;
    col_ok  = (colw < XW'(cfg_i.map_cols)) && (colw < XW'(MAX_COLS));
    row_ok  = !yp[YW-1] && (roww < YW'(cfg_i.map_rows)) && (roww < YW'(MAX_ROWS));
    in_map  = col_ok && row_ok;
    raddr   = AW'(roww[RIW-1:0]) * AW'(MAX_COLS) + AW'(colw[CIW-1:0]);
  end

  assign w_ok  = (int'(w_row) < MAX_ROWS) && (int'(w_col) < MAX_COLS);
  assign waddr = AW'(w_row) * AW'(MAX_COLS) + AW'(w_col);

  grh_map #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.map_write && w_ok),
    .waddr_i (waddr),
    .wdata_i (w_wall),
    .re_i    (cmd_i.issue && in_map),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_load) begin
      px_q    <= s_px;
      cot_q   <= $signed(s_cot);
      diff_q  <= $signed(diff[DIFF_W-1:0]);
      y0_q    <= y0;
      ys_q    <= s_tdata_i[grh_pkg::S_UP_BIT] ? -th : th;
      up_q    <= s_tdata_i[grh_pkg::S_UP_BIT];
      left_q  <= s_tdata_i[grh_pkg::S_LEFT_BIT];
      right_q <= s_tdata_i[grh_pkg::S_RIGHT_BIT];
    end
    if (cmd_i.mul) begin
      prod_q <= diff_q * cot_q;
      xs_q   <= xs2;
    end
    if (cmd_i.init) begin
      x_q <= x0;
      y_q <= y0_q;
    end else if (cmd_i.issue) begin
      x_q <= x_q + xs_q;
      y_q <= y_q + ys_q;
    end
    if (cmd_i.issue) begin
      pr_x_q    <= x_q[POS_W-1:0];
      pr_y_q    <= y_q[POS_W-1:0];
      pr_view_q <= in_view;
      pr_map_q  <= in_map;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q <= 1'b0;
    end else begin
      pr_valid_q <= cmd_i.issue;
    end
  end

  assign found = pr_view_q && pr_map_q && rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_x_q <= found ? pr_x_q : '0;
      out_y_q <= found ? pr_y_q : '0;
      out_f_q <= found;
    end
  end

  assign sts_o.stop     = pr_valid_q && (!pr_view_q || (pr_map_q && rdata));
  assign sts_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_y_q, out_x_q};
  assign m_tuser_o  = out_f_q;

endmodule

### rtl/grh_ctrl.sv
module grh_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  input  logic                               s_opcode_i,
  output logic                               s_ready_o,
  input  grh_pkg::sts_t                      sts_i,
  output grh_pkg::cmd_t                      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_INIT = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_opcode_i == grh_pkg::OP_CAST) begin
            cmd_o.cast_load = 1'b1;
            state_d         = ST_MUL;
          end else begin
            cmd_o.map_write = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        // probe one row per cycle; the previous probe is judged as the next issues
        if (sts_i.stop) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/grid_ray_horizontal_hit.sv
// Map write: taken while idle, no result. Cast: the item is latched, the x
// step is formed, the walk point is loaded, then rows are probed (one map
// read per row per cycle) until one hits a wall or leaves the view. No new
// item is taken until the result is in the output register, where it waits.
// Reset: configuration returns to its defaults, the controller idles and the
// output is invalid; wall map contents are undefined until written.
module grid_ray_horizontal_hit #(
  parameter int MAX_ROWS = grh_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = grh_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // row[5:0] col[11:6] wall[12] player_x[36:13] player_y[60:37]
  // ray_cot[84:61] up[85] down[86] left[87] right[88], zero above
  input  logic [grh_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // opcode[0]
  input  logic [grh_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit_x[23:0] hit_y[47:24]
  output logic [grh_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // hit_found[0]
  output logic [grh_pkg::M_TUSER_W-1:0]      m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [grh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [grh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  grh_pkg::cfg_t cfg;
  grh_pkg::cmd_t cmd;
  grh_pkg::sts_t sts;

  grh_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  grh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_opcode_i (s_axis_tuser[0]),
    .s_ready_o  (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grh_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

### rtl/grh_checker.sv
module grh_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [grh_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [grh_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input logic [grh_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss carries a nonzero hit point");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == grh_pkg::OP_WRITE)
      && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("map write produced a result");

  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input was open");

endmodule

bind grid_ray_horizontal_hit grh_checker u_grh_checker (.*);
